[rtl/assert_macros.svh]
// assertion macros used by the sampler top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on an explicit clock and active-low reset
`define CWS_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cws assertion failed");

// concurrent check on the block clock and reset
`define CWS_ASSERT(label, prop) `CWS_ASSERT_CLK(label, i_clk, i_rst_n, prop)

`endif

[rtl/cws_pkg.sv]
// shared constants, types and helpers of the categorical weighted sampler
package cws_pkg;

    localparam int MAX_CATEGORIES = 16;
    localparam int WEIGHT_BITS    = 16;

    localparam int IDX_W     = $clog2(MAX_CATEGORIES);
    localparam int CNT_W     = $clog2(MAX_CATEGORIES + 1);
    localparam int TOT_W     = WEIGHT_BITS + IDX_W;
    localparam int FRAC_W    = 16;
    localparam int THR_W     = TOT_W + FRAC_W;
    localparam int QUO_W     = FRAC_W + 1;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_EVAL   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_LATCH,
        S_WALK,
        S_PICK,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  entry_index;
        logic [15:0] weight;
        logic [15:0] uniform_sample;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  chosen_index;
        logic [15:0] probability;
        logic        index_error;
    } t_out_item;

    // record that travels down the cell row
    typedef struct packed {
        logic [TOT_W-1:0]       acc;
        logic                   found;
        logic [IDX_W-1:0]       pick;
        logic [WEIGHT_BITS-1:0] pw;
    } t_wave;

    // controls broadcast to every cell
    typedef struct packed {
        logic                   walk;
        logic [CNT_W-1:0]       count;
        logic [IDX_W-1:0]       target;
        logic [THR_W-1:0]       thr;
        logic                   wr_en;
        logic [IDX_W-1:0]       wr_idx;
        logic [WEIGHT_BITS-1:0] wr_data;
    } t_ctl;

    // register value to number of active entries
    function automatic logic [CNT_W-1:0] active_count(input logic [4:0] c);
        int v;
        v = int'(c);
        if (v == 0) v = 1;
        if (v > MAX_CATEGORIES) v = MAX_CATEGORIES;
        return CNT_W'(v);
    endfunction

endpackage

[rtl/categorical_weighted_sampler_top.sv]
// top level of the categorical weighted sampler: sequencer, divider, output register
//
//  channel | direction | signals                          | moves
//  --------+-----------+----------------------------------+---------------------------
//  in      | input     | i_in_valid o_in_ready i_in       | command transaction
//  out     | output    | o_out_valid i_out_ready o_out    | result transaction
//  cfg     | input     | i_cfg_valid o_cfg_ready i_cfg_data | category_count write
//
//  write and unused commands finish in the idle state; an out-of-range evaluate goes straight to done
//  evaluate: total pass through the cell row, latch, divider, done
//  sample: total pass, latch with the u * total multiply, cumulative walk, pick,
//  divider, done; each pass spans the full row of MAX_CATEGORIES cells and the
//  divider loop makes one quotient bit per cycle
//  reset puts every weight to one and category_count to 16, no clearing pass
//  a new command is taken while a result waits in the output register; a second
//  result holds in the done state until the output register frees up
`include "assert_macros.svh"

module categorical_weighted_sampler_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cws_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cws_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [4:0]         i_cfg_data
);

    // sequencer state
    cws_pkg::t_state                   r_state, n_state;
    logic [cws_pkg::IDX_W-1:0]         r_cnt, n_cnt;
    logic [cws_pkg::DIV_CNT_W-1:0]     r_div_cnt, n_div_cnt;
    logic                              r_is_sample, n_is_sample;
    logic                              r_err, n_err;

    // captured operands and working values
    logic [3:0]                        r_target, n_target;
    logic [15:0]                       r_u, n_u;
    logic [cws_pkg::TOT_W-1:0]         r_total, n_total;
    logic [cws_pkg::THR_W-1:0]         r_thr, n_thr;
    logic [cws_pkg::WEIGHT_BITS-1:0]   r_pw, n_pw;
    logic [cws_pkg::IDX_W-1:0]         r_pick, n_pick;
    logic [cws_pkg::TOT_W-1:0]         r_rem, n_rem;
    logic [cws_pkg::QUO_W-1:0]         r_quo, n_quo;

    // result register and configuration
    cws_pkg::t_out_item                r_out, n_out;
    logic                              r_out_valid, n_out_valid;
    logic [4:0]                        r_cat_count;

    // cell row
    cws_pkg::t_ctl                     w_ctl;
    cws_pkg::t_wave                    w_head;
    cws_pkg::t_wave                    w_tail;
    logic [cws_pkg::CNT_W-1:0]         w_count;
    logic                              w_in_acc;
    logic [cws_pkg::WEIGHT_BITS-1:0]   w_wr_weight;

    // divider step
    logic [cws_pkg::TOT_W:0]           w_rem2;
    logic                              w_qbit;
    logic [15:0]                       w_prob;

    assign o_in_ready  = (r_state == cws_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_count     = cws_pkg::active_count(r_cat_count);
    assign w_wr_weight = cws_pkg::WEIGHT_BITS'(i_in.weight);

    // broadcast controls, writes land on the cells straight from the input
    always_comb begin
        w_ctl.walk    = (r_state == cws_pkg::S_WALK);
        w_ctl.count   = w_count;
        w_ctl.target  = cws_pkg::IDX_W'(r_target);
        w_ctl.thr     = r_thr;
        w_ctl.wr_en   = w_in_acc && (i_in.cmd == cws_pkg::CMD_WRITE)
                        && (32'(i_in.entry_index) < 32'(cws_pkg::MAX_CATEGORIES));
        w_ctl.wr_idx  = cws_pkg::IDX_W'(i_in.entry_index);
        w_ctl.wr_data = (w_wr_weight == '0) ? cws_pkg::WEIGHT_BITS'(1) : w_wr_weight;
    end

    // empty record enters the head of the row every cycle
    assign w_head = '0;

    cws_chain u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_head (w_head),
        .o_tail (w_tail)
    );

    // restoring divide: the first step shifts in the low weight bit, then zeros
    assign w_rem2 = {r_rem, (r_div_cnt == '0) ? r_pw[0] : 1'b0};
    assign w_qbit = (w_rem2 >= {1'b0, r_total});

    // quotient can reach one exactly, clamp to the top code
    assign w_prob = r_quo[cws_pkg::QUO_W-1] ? 16'hFFFF : r_quo[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cws_pkg::S_IDLE;
            r_cnt       <= '0;
            r_div_cnt   <= '0;
            r_is_sample <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
            r_cat_count <= 5'd16;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_div_cnt   <= n_div_cnt;
            r_is_sample <= n_is_sample;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cat_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_target <= n_target;
        r_u      <= n_u;
        r_total  <= n_total;
        r_thr    <= n_thr;
        r_pw     <= n_pw;
        r_pick   <= n_pick;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_div_cnt   = r_div_cnt;
        n_is_sample = r_is_sample;
        n_err       = r_err;
        n_target    = r_target;
        n_u         = r_u;
        n_total     = r_total;
        n_thr       = r_thr;
        n_pw        = r_pw;
        n_pick      = r_pick;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            cws_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_target = i_in.entry_index;
                    n_u      = i_in.uniform_sample;
                    n_cnt    = '0;
                    n_err    = 1'b0;
                    if (i_in.cmd == cws_pkg::CMD_SAMPLE) begin
                        n_is_sample = 1'b1;
                        n_state     = cws_pkg::S_SUM;
                    end else if (i_in.cmd == cws_pkg::CMD_EVAL) begin
                        n_is_sample = 1'b0;
                        if (32'(i_in.entry_index) >= 32'(w_count)) begin
                            // index past the active entries: error, zero probability
                            n_err   = 1'b1;
                            n_quo   = '0;
                            n_state = cws_pkg::S_DONE;
                        end else begin
                            n_state = cws_pkg::S_SUM;
                        end
                    end
                end
            end
            cws_pkg::S_SUM: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == cws_pkg::IDX_W'(cws_pkg::MAX_CATEGORIES - 1)) begin
                    n_state = cws_pkg::S_LATCH;
                end
            end
            cws_pkg::S_LATCH: begin
                // total is at the tail, form u * total for the walk
                n_total   = w_tail.acc;
                n_thr     = cws_pkg::THR_W'(r_u) * cws_pkg::THR_W'(w_tail.acc);
                n_pw      = w_tail.pw;
                n_rem     = cws_pkg::TOT_W'(w_tail.pw >> 1);
                n_quo     = '0;
                n_div_cnt = '0;
                n_cnt     = '0;
                n_state   = r_is_sample ? cws_pkg::S_WALK : cws_pkg::S_DIV;
            end
            cws_pkg::S_WALK: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == cws_pkg::IDX_W'(cws_pkg::MAX_CATEGORIES - 1)) begin
                    n_state = cws_pkg::S_PICK;
                end
            end
            cws_pkg::S_PICK: begin
                n_pick    = w_tail.pick;
                n_pw      = w_tail.pw;
                n_rem     = cws_pkg::TOT_W'(w_tail.pw >> 1);
                n_quo     = '0;
                n_div_cnt = '0;
                n_state   = cws_pkg::S_DIV;
            end
            cws_pkg::S_DIV: begin
                n_rem     = w_qbit ? cws_pkg::TOT_W'(w_rem2 - {1'b0, r_total})
                                   : cws_pkg::TOT_W'(w_rem2);
                n_quo     = {r_quo[cws_pkg::QUO_W-2:0], w_qbit};
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == cws_pkg::DIV_CNT_W'(cws_pkg::QUO_W - 1)) begin
                    n_state = cws_pkg::S_DONE;
                end
            end
            cws_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.chosen_index = r_is_sample ? 4'(r_pick) : r_target;
                    n_out.probability  = r_err ? 16'd0 : w_prob;
                    n_out.index_error  = r_err;
                    n_out_valid        = 1'b1;
                    n_state            = cws_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cws_pkg::S_IDLE;
            end
        endcase
    end

    // an error result never carries a probability
    `CWS_ASSERT(a_err_zero_prob, (o_out_valid && o_out.index_error) |-> (o_out.probability == 16'd0))
    // a good result names an active entry
    `CWS_ASSERT(a_index_active, (o_out_valid && !o_out.index_error) |-> (32'(o_out.chosen_index) < 32'(w_count)))
    // divide runs with a nonzero total no smaller than the picked weight
    `CWS_ASSERT(a_div_operands, (r_state == cws_pkg::S_DIV) |-> ((r_total != '0) && (cws_pkg::TOT_W'(r_pw) <= r_total)))
    // an accepted sample starts the total pass
    `CWS_ASSERT(a_sample_start, (w_in_acc && (i_in.cmd == cws_pkg::CMD_SAMPLE)) |=> (r_state == cws_pkg::S_SUM))

endmodule

[rtl/cws_cell.sv]
// one weight cell: holds a weight and updates the passing record
module cws_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [cws_pkg::IDX_W-1:0] i_pos,
    input  cws_pkg::t_ctl             i_ctl,
    input  cws_pkg::t_wave            i_wave,
    output cws_pkg::t_wave            o_wave
);

    logic [cws_pkg::WEIGHT_BITS-1:0] r_weight;
    cws_pkg::t_wave                  r_wave;
    cws_pkg::t_wave                  n_wave;
    logic                            w_active;
    logic [cws_pkg::TOT_W-1:0]       w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= cws_pkg::WEIGHT_BITS'(1);
        end else if (i_ctl.wr_en && (i_ctl.wr_idx == i_pos)) begin
            r_weight <= i_ctl.wr_data;
        end
    end

    assign w_active = (cws_pkg::CNT_W'(i_pos) < i_ctl.count);
    assign w_sum    = i_wave.acc + cws_pkg::TOT_W'(r_weight);

    always_comb begin
        n_wave = i_wave;
        if (!i_ctl.walk) begin
            // total pass, also grabs the evaluated entry
            if (w_active) n_wave.acc = w_sum;
            if (i_pos == i_ctl.target) n_wave.pw = r_weight;
        end else if (w_active && !i_wave.found) begin
            // cumulative walk, last active entry stays picked if nothing hits
            n_wave.acc  = w_sum;
            n_wave.pick = i_pos;
            n_wave.pw   = r_weight;
            if ({w_sum, {cws_pkg::FRAC_W{1'b0}}} >= i_ctl.thr) n_wave.found = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wave <= n_wave;
    end

    assign o_wave = r_wave;

endmodule

[rtl/cws_chain.sv]
// row of weight cells, the record moves one cell per cycle
module cws_chain (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cws_pkg::t_ctl  i_ctl,
    input  cws_pkg::t_wave i_head,
    output cws_pkg::t_wave o_tail
);

    cws_pkg::t_wave w_link [cws_pkg::MAX_CATEGORIES+1];

    assign w_link[0] = i_head;

    for (genvar g = 0; g < cws_pkg::MAX_CATEGORIES; g++) begin : g_cell
        cws_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_pos  (cws_pkg::IDX_W'(g)),
            .i_ctl  (i_ctl),
            .i_wave (w_link[g]),
            .o_wave (w_link[g+1])
        );
    end

    assign o_tail = w_link[cws_pkg::MAX_CATEGORIES];

endmodule

[verif/tb_top.sv]
// self-checking testbench of the categorical weighted sampler top level

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // command code that the block ignores, it has no enum member
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // settle time after the last result, gives any in-flight command room
    localparam int SETTLE_CYCLES = 80;
    // watchdog limit on the whole run, well above the slowest legal run
    localparam int LIMIT_CYCLES  = 500000;
    localparam int N_DIRECTED    = 24;
    localparam int N_SEGMENTS    = 8;
    localparam int SEG_ITEMS     = 141;

    // one row of the directed table, an optional count write ahead of the command
    typedef struct {
        bit          cfg_wr;
        logic [4:0]  cfg_val;
        logic [1:0]  cmd;
        logic [3:0]  idx;
        logic [15:0] w;
        logic [15:0] u;
        bit          typed;
        logic [3:0]  want_idx;
        logic [15:0] want_p;
        logic        want_e;
    } t_dir_row;

    // dut ports, every input known from time zero
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    cws_pkg::t_in_item  i_in        = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    cws_pkg::t_out_item o_out;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [4:0]         i_cfg_data  = 5'd0;

    // typed expectation travels with the command it belongs to
    bit                 drv_typed = 1'b0;
    cws_pkg::t_out_item drv_want  = '0;

    // predictor state, mirrors the weight table and the count register
    logic [15:0] weight_mem [cws_pkg::MAX_CATEGORIES];
    logic [4:0]  count_reg;

    // expected result transactions, newest at the front, oldest at the back
    cws_pkg::t_out_item result_q [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_cnt      = 0;
    int unsigned err_cnt        = 0;
    int unsigned n_cmds         = 0;
    int unsigned n_samples      = 0;
    int unsigned n_evals        = 0;
    int unsigned n_flagged      = 0;
    int unsigned n_cfg          = 0;

    // directed table: reset state, clamping, out-of-range evaluates, count extremes
    t_dir_row dir_tbl [N_DIRECTED] = '{
        // after reset every weight is one and sixteen entries are active
        '{1'b0, 5'd0, cws_pkg::CMD_EVAL, 4'd0, 16'h0000, 16'h0000, 1'b1, 4'd0, 16'd4096, 1'b0},
        '{1'b0, 5'd0, cws_pkg::CMD_EVAL, 4'd15, 16'h0000, 16'h0000, 1'b1, 4'd15, 16'd4096, 1'b0},
        '{1'b0, 5'd0, cws_pkg::CMD_SAMPLE, 4'd0, 16'h0000, 16'h0000, 1'b1, 4'd0, 16'd4096, 1'b0},
        '{1'b0, 5'd0, cws_pkg::CMD_SAMPLE, 4'd0, 16'h0000, 16'hFFFF, 1'b1, 4'd15, 16'd4096, 1'b0},
        // ignored command with every field bit set
        '{1'b0, 5'd0, CMD_UNUSED, 4'd15, 16'hFFFF, 16'hFFFF, 1'b0, 4'd0, 16'd0, 1'b0},
        // zero weight lands as one, then the extremes of the weight field
        '{1'b0, 5'd0, cws_pkg::CMD_WRITE, 4'd3, 16'h0000, 16'h0000, 1'b0, 4'd0, 16'd0, 1'b0},
        '{1'b0, 5'd0, cws_pkg::CMD_WRITE, 4'd15, 16'hFFFF, 16'h0000, 1'b0, 4'd0, 16'd0, 1'b0},
        '{1'b0, 5'd0, cws_pkg::CMD_WRITE, 4'd0, 16'hFFFF, 16'h0000, 1'b0, 4'd0, 16'd0, 1'b0},
        '{1'b0, 5'd0, cws_pkg::CMD_SAMPLE, 4'd0, 16'h0000, 16'h8000, 1'b0, 4'd0, 16'd0, 1'b0},
        '{1'b0, 5'd0, cws_pkg::CMD_SAMPLE, 4'd0, 16'h0000, 16'hFFFF, 1'b0, 4'd0, 16'd0, 1'b0},
        '{1'b0, 5'd0, cws_pkg::CMD_EVAL, 4'd15, 16'h0000, 16'h0000, 1'b0, 4'd0, 16'd0, 1'b0},
        '{1'b0, 5'd0, cws_pkg::CMD_EVAL, 4'd3, 16'h0000, 16'h0000, 1'b0, 4'd0, 16'd0, 1'b0},
        // single active entry, full share clamps to the top code
        '{1'b1, 5'd1, cws_pkg::CMD_EVAL, 4'd0, 16'h0000, 16'h0000, 1'b1, 4'd0, 16'hFFFF, 1'b0},
        '{1'b0, 5'd0, cws_pkg::CMD_EVAL, 4'd1, 16'h0000, 16'h0000, 1'b1, 4'd1, 16'd0, 1'b1},
        '{1'b0, 5'd0, cws_pkg::CMD_SAMPLE, 4'd9, 16'h1234, 16'hFFFF, 1'b1, 4'd0, 16'hFFFF, 1'b0},
        // count of zero behaves as one
        '{1'b1, 5'd0, cws_pkg::CMD_EVAL, 4'd15, 16'h0000, 16'h0000, 1'b1, 4'd15, 16'd0, 1'b1},
        '{1'b0, 5'd0, cws_pkg::CMD_SAMPLE, 4'd0, 16'h0000, 16'h1234, 1'b1, 4'd0, 16'hFFFF, 1'b0},
        // count above the table size behaves as sixteen
        '{1'b1, 5'd31, cws_pkg::CMD_EVAL, 4'd15, 16'h0000, 16'h0000, 1'b0, 4'd0, 16'd0, 1'b0},
        '{1'b0, 5'd0, cws_pkg::CMD_SAMPLE, 4'd0, 16'h0000, 16'h0000, 1'b0, 4'd0, 16'd0, 1'b0},
        // partial table, evaluate just past the active range
        '{1'b1, 5'd5, cws_pkg::CMD_EVAL, 4'd5, 16'h0000, 16'h0000, 1'b1, 4'd5, 16'd0, 1'b1},
        '{1'b0, 5'd0, cws_pkg::CMD_EVAL, 4'd4, 16'h0000, 16'h0000, 1'b0, 4'd0, 16'd0, 1'b0},
        '{1'b0, 5'd0, cws_pkg::CMD_WRITE, 4'd2, 16'h0001, 16'h0000, 1'b0, 4'd0, 16'd0, 1'b0},
        '{1'b0, 5'd0, cws_pkg::CMD_SAMPLE, 4'd0, 16'h0000, 16'hC000, 1'b0, 4'd0, 16'd0, 1'b0},
        '{1'b1, 5'd16, cws_pkg::CMD_EVAL, 4'd0, 16'h0000, 16'h0000, 1'b0, 4'd0, 16'd0, 1'b0}
    };

    categorical_weighted_sampler_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // receiver side, stalls at the rate of the current phase
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // register value to number of entries in use
    function automatic int unsigned active_n(input logic [4:0] c);
        if (c == 5'd0) return 1;
        if (c > cws_pkg::MAX_CATEGORIES) return cws_pkg::MAX_CATEGORIES;
        return int'(c);
    endfunction

    // truncated q0.16 share of one weight, clamped to the top code
    function automatic logic [15:0] q16_share(input longint unsigned w,
                                              input longint unsigned total);
        longint unsigned p;
        p = (w << 16) / total;
        return (p > 64'hFFFF) ? 16'hFFFF : p[15:0];
    endfunction

    function automatic void weights_reset();
        for (int i = 0; i < cws_pkg::MAX_CATEGORIES; i++) weight_mem[i] = 16'd1;
        count_reg = 5'd16;
    endfunction

    // applies one command to the predictor state, returns 1 when it yields a result
    function automatic bit predict_command(input cws_pkg::t_in_item it,
                                           output cws_pkg::t_out_item res);
        int unsigned     n;
        longint unsigned total;
        longint unsigned thr;
        longint unsigned run;
        logic [3:0]      pick;
        bit              found;
        res   = '0;
        n     = active_n(count_reg);
        total = 0;
        for (int i = 0; i < n; i++) total += weight_mem[i];
        case (it.cmd)
            cws_pkg::CMD_WRITE: begin
                weight_mem[it.entry_index] = (it.weight == 16'd0) ? 16'd1 : it.weight;
                return 1'b0;
            end
            cws_pkg::CMD_SAMPLE: begin
                // inverse cdf walk, first entry whose scaled running sum reaches u * total
                thr   = longint'(it.uniform_sample) * total;
                run   = 0;
                found = 1'b0;
                pick  = 4'(n - 1);
                for (int i = 0; i < n; i++) begin
                    run += weight_mem[i];
                    if (!found && (run << 16) >= thr) begin
                        pick  = 4'(i);
                        found = 1'b1;
                    end
                end
                res.chosen_index = pick;
                res.probability  = q16_share(weight_mem[pick], total);
                res.index_error  = 1'b0;
                return 1'b1;
            end
            cws_pkg::CMD_EVAL: begin
                res.chosen_index = it.entry_index;
                if (it.entry_index >= n) begin
                    res.probability = 16'd0;
                    res.index_error = 1'b1;
                end else begin
                    res.probability = q16_share(weight_mem[it.entry_index], total);
                    res.index_error = 1'b0;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        err_cnt++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    endtask

    // monitor: predicts on every accepted command, checks every accepted result
    always @(posedge i_clk) begin : monitor
        cws_pkg::t_out_item pred;
        cws_pkg::t_out_item want;
        bit                 has_res;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) count_reg = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                has_res = predict_command(i_in, pred);
                // typed rows carry their own expectation, the predictor still tracks state
                if (has_res) result_q.push_front(drv_typed ? drv_want : pred);
            end
            if (o_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none actual %0d/%0d/%0d",
                             $time, o_out.chosen_index, o_out.probability,
                             o_out.index_error);
                end else begin
                    want = result_q.pop_back();
                    if (o_out.chosen_index !== want.chosen_index)
                        report_mismatch("chosen_index", want.chosen_index, o_out.chosen_index);
                    if (o_out.probability !== want.probability)
                        report_mismatch("probability", want.probability, o_out.probability);
                    if (o_out.index_error !== want.index_error)
                        report_mismatch("index_error", want.index_error, o_out.index_error);
                    if (o_out.index_error === 1'b1) n_flagged++;
                end
            end
        end
    end

    // one command transaction, then sender idle cycles at the phase rate
    task automatic send_command(input cws_pkg::t_in_item it, input bit typed,
                                input cws_pkg::t_out_item want);
        i_in       <= it;
        drv_typed  <= typed;
        drv_want   <= want;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        n_cmds++;
        if (it.cmd == cws_pkg::CMD_SAMPLE) n_samples++;
        if (it.cmd == cws_pkg::CMD_EVAL) n_evals++;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // hold the sender until every expected result is back, then let writes settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        // step past the edge so the monitor has pushed and popped for it
        do begin
            @(posedge i_clk);
            #1;
        end while (result_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // count register write, only with the block idle
    task automatic write_count(input logic [4:0] v);
        drain_results();
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    // random command, weights and fractions biased toward extremes and small values
    function automatic cws_pkg::t_in_item random_command(input int unsigned n);
        cws_pkg::t_in_item it;
        int unsigned       roll;
        it.entry_index = 4'($urandom_range(15));
        roll = $urandom_range(9);
        if (roll == 0) it.weight = 16'h0000;
        else if (roll == 1) it.weight = 16'hFFFF;
        else if (roll < 6) it.weight = 16'($urandom_range(16, 1));
        else it.weight = 16'($urandom);
        roll = $urandom_range(19);
        if (roll == 0) it.uniform_sample = 16'h0000;
        else if (roll == 1) it.uniform_sample = 16'hFFFF;
        else it.uniform_sample = 16'($urandom);
        roll = $urandom_range(99);
        if (roll < 30) begin
            it.cmd = cws_pkg::CMD_WRITE;
        end else if (roll < 70) begin
            it.cmd = cws_pkg::CMD_SAMPLE;
        end else if (roll < 95) begin
            // mostly inside the active range, now and then anywhere
            it.cmd = cws_pkg::CMD_EVAL;
            if ($urandom_range(3) != 0) it.entry_index = 4'($urandom_range(n - 1));
        end else begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    // timeout watchdog
    initial begin
        while (cycle_cnt < LIMIT_CYCLES) @(posedge i_clk);
        $display("%0t: timeout with %0d results still expected", $time, result_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // main stimulus
    initial begin : stimulus
        cws_pkg::t_in_item  it;
        cws_pkg::t_out_item want;
        logic [4:0]         seg_count [N_SEGMENTS];
        logic [4:0]         cur_count;
        int unsigned        mode;

        weights_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling on either side
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (dir_tbl[r].cfg_wr) write_count(dir_tbl[r].cfg_val);
            it.cmd            = dir_tbl[r].cmd;
            it.entry_index    = dir_tbl[r].idx;
            it.weight         = dir_tbl[r].w;
            it.uniform_sample = dir_tbl[r].u;
            want.chosen_index = dir_tbl[r].want_idx;
            want.probability  = dir_tbl[r].want_p;
            want.index_error  = dir_tbl[r].want_e;
            send_command(it, dir_tbl[r].typed, want);
        end

        // random part, each segment on its own count setting and idling phase
        seg_count[0] = 5'd16;
        seg_count[1] = 5'd1;
        seg_count[2] = 5'd31;
        seg_count[3] = 5'd0;
        seg_count[4] = 5'($urandom_range(15, 2));
        seg_count[5] = 5'd15;
        seg_count[6] = 5'($urandom_range(31));
        seg_count[7] = 5'd2;
        for (int s = 0; s < N_SEGMENTS; s++) begin
            cur_count = seg_count[s];
            write_count(cur_count);
            mode = s % 4;
            // phases: none, sender idle, receiver stall, both lightly
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 50; end
                default: begin send_idle_pct = 17; recv_stall_pct <= 17; end
            endcase
            for (int k = 0; k < SEG_ITEMS; k++) begin
                // halfway through, the sender waits for every result to come back
                if (k == SEG_ITEMS / 2) drain_results();
                send_command(random_command(active_n(cur_count)), 1'b0, '0);
            end
        end

        drain_results();
        $display("covered %0d commands: %0d samples, %0d evaluates, %0d out-of-range flags",
                 n_cmds, n_samples, n_evals, n_flagged);
        $display("over %0d count register writes and four idling phases", n_cfg);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/cws_pkg.sv
rtl/cws_cell.sv
rtl/cws_chain.sv
rtl/categorical_weighted_sampler_top.sv
verif/tb_top.sv
